// ===== hw/rtl/battery_level_gauge_defines.svh =====
// ----------------------------------------------------------------------------
// Battery level gauge assertion macros
// Shared concurrent check macros, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

// Same-cycle implication.
`define BLG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("battery level gauge check failed");

// Next-cycle implication.
`define BLG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("battery level gauge check failed");

`endif

// ===== hw/rtl/blg_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level gauge package
// Field widths, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int THR_BITS       = 12;
  localparam int HYST_BITS      = 10;
  localparam int SHIFT_BITS     = 4;
  localparam int LIMIT_BITS     = 3;
  localparam int LEVEL_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  typedef enum logic [2:0] {
    ST_UNAVAILABLE = 3'd0,
    ST_FAULT       = 3'd1,
    ST_CHARGING    = 3'd2,
    ST_COMPLETE    = 3'd3,
    ST_LOW         = 3'd4,
    ST_ON_BATTERY  = 3'd5
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD_ONE     = 3'd0,
    REG_THRESHOLD_TWO     = 3'd1,
    REG_THRESHOLD_THREE   = 3'd2,
    REG_HYSTERESIS_COUNTS = 3'd3,
    REG_AVERAGE_SHIFT     = 3'd4,
    REG_LOW_LEVEL_LIMIT   = 3'd5
  } cfg_reg_t;

endpackage

// ===== hw/rtl/blg_read_if.sv =====
// ----------------------------------------------------------------------------
// Battery read channel
// Valid/ready channel carrying one ADC read and the charger pins.
// ----------------------------------------------------------------------------
interface blg_read_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   read_valid;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   power_good;
  logic                   charge_active;

  modport source (output valid, read_valid, sample, power_good, charge_active,
                  input ready);
  modport sink   (input valid, read_valid, sample, power_good, charge_active,
                  output ready);
endinterface

// ===== hw/rtl/blg_result_if.sv =====
// ----------------------------------------------------------------------------
// Battery result channel
// Valid/ready channel carrying the gauge level, status and running average.
// ----------------------------------------------------------------------------
interface blg_result_if
  import blg_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [LEVEL_BITS-1:0]  battery_level;
  status_t                battery_status;
  logic [SAMPLE_BITS-1:0] filtered_value;

  modport source (output valid, battery_level, battery_status, filtered_value,
                  input ready);
  modport sink   (input valid, battery_level, battery_status, filtered_value,
                  output ready);
endinterface

// ===== hw/rtl/battery_level_gauge.sv =====
// ----------------------------------------------------------------------------
// Battery level gauge
// Running-average filter on ADC reads, hysteresis level quantizer and status.
// ----------------------------------------------------------------------------
// Usage:
//   reads   : one transfer per ADC read (read_valid, sample, charger pins).
//   results : one transfer per read: battery_level, battery_status and
//             filtered_value, all taken after that read is applied.
//   cfg_*   : write port for thresholds, hysteresis, filter shift and low
//             limit; write only while no read is in flight.
// The read register loads on the read transfer and the filter/quantizer
// update then loads the result register from it, once that register is
// empty or being emptied. One read is taken per cycle while the receiver
// does not stall; the single filter/quantizer update per cycle is what
// sets that rate.
// Reset clears the average, level and read history and loads the register
// defaults; results then report unavailable (fault on a charging pin
// without power) with level zero until the first good read.
// When the receiver stalls, the result register holds, the read register
// fills and then reads back-pressure; no transfer is dropped or repeated.
// ----------------------------------------------------------------------------
`include "battery_level_gauge_defines.svh"

module battery_level_gauge
  import blg_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  blg_read_if.sink                  reads,
  blg_result_if.source              results,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Compare width: holds the average, a threshold plus hysteresis and a sign.
  localparam int MAXW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int CW   = MAXW + 2;
  localparam int DW   = SAMPLE_BITS + 1;

  typedef struct packed {
    logic                   read_valid;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   power_good;
    logic                   charge_active;
  } read_t;

  // Configuration registers
  logic [THR_BITS-1:0]   threshold_one;
  logic [THR_BITS-1:0]   threshold_two;
  logic [THR_BITS-1:0]   threshold_three;
  logic [HYST_BITS-1:0]  hysteresis_counts;
  logic [SHIFT_BITS-1:0] average_shift;
  logic [LIMIT_BITS-1:0] low_level_limit;

  // Gauge state; average_loaded doubles as "a valid read was ever seen"
  logic [SAMPLE_BITS-1:0] running_average;
  logic                   average_loaded;
  logic [LEVEL_BITS-1:0]  current_level;
  logic                   last_read_good;

  // Read register and result register
  logic  s1_valid;
  read_t s1;
  logic  advance;

  logic [SAMPLE_BITS-1:0] running_average_next;
  logic [LEVEL_BITS-1:0]  current_level_next;
  status_t                status_next;

  // --------------------------------------------------------------------------
  // Configuration writes; indexes past the list are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_one     <= THR_BITS'(1024);
      threshold_two     <= THR_BITS'(2048);
      threshold_three   <= THR_BITS'(3072);
      hysteresis_counts <= HYST_BITS'(32);
      average_shift     <= SHIFT_BITS'(3);
      low_level_limit   <= LIMIT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD_ONE:     threshold_one     <= cfg_data[THR_BITS-1:0];
        REG_THRESHOLD_TWO:     threshold_two     <= cfg_data[THR_BITS-1:0];
        REG_THRESHOLD_THREE:   threshold_three   <= cfg_data[THR_BITS-1:0];
        REG_HYSTERESIS_COUNTS: hysteresis_counts <= cfg_data[HYST_BITS-1:0];
        REG_AVERAGE_SHIFT:     average_shift     <= cfg_data[SHIFT_BITS-1:0];
        REG_LOW_LEVEL_LIMIT:   low_level_limit   <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the update stage advances whenever the result register is
  // empty or being emptied; the read register refills in the same cycle.
  // --------------------------------------------------------------------------
  assign advance     = !results.valid || results.ready;
  assign reads.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (reads.ready) begin
      s1_valid <= reads.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reads.valid && reads.ready) begin
      s1.read_valid    <= reads.read_valid;
      s1.sample        <= reads.sample;
      s1.power_good    <= reads.power_good;
      s1.charge_active <= reads.charge_active;
    end
  end

  // --------------------------------------------------------------------------
  // Running average: add (sample - average) / 2^shift, truncated toward zero.
  // Arithmetic shift floors; bump by one when a negative difference lost bits.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] quot;
  logic        [DW-1:0] lost_mask;
  logic                 round_up;
  logic signed [DW-1:0] sum;

  always_comb begin
    diff      = $signed({1'b0, s1.sample}) - $signed({1'b0, running_average});
    quot      = diff >>> average_shift;
    lost_mask = ~({DW{1'b1}} << average_shift);
    round_up  = diff[DW-1] && ((diff & lost_mask) != '0);
    sum       = $signed({1'b0, running_average}) + quot + $signed(DW'(round_up));
    if (!s1.read_valid) begin
      running_average_next = running_average;
    end else if (!average_loaded) begin
      running_average_next = s1.sample;
    end else begin
      running_average_next = sum[SAMPLE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Level quantizer with hysteresis.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]  avg_c;
  logic signed [CW-1:0]  t1_c;
  logic signed [CW-1:0]  t2_c;
  logic signed [CW-1:0]  t3_c;
  logic signed [CW-1:0]  hyst_c;
  logic signed [CW-1:0]  thr_up;
  logic signed [CW-1:0]  thr_dn;
  logic [LEVEL_BITS-1:0] raw_level;

  always_comb begin
    avg_c  = $signed(CW'(running_average_next));
    t1_c   = $signed(CW'(threshold_one));
    t2_c   = $signed(CW'(threshold_two));
    t3_c   = $signed(CW'(threshold_three));
    hyst_c = $signed(CW'(hysteresis_counts));

    // Highest threshold exceeded wins, each tested on its own.
    raw_level = LEVEL_BITS'(1);
    if (avg_c > t1_c) raw_level = LEVEL_BITS'(2);
    if (avg_c > t2_c) raw_level = LEVEL_BITS'(3);
    if (avg_c > t3_c) raw_level = LEVEL_BITS'(4);

    // Threshold just above and just below the current level
    case (current_level)
      LEVEL_BITS'(1): thr_up = t1_c;
      LEVEL_BITS'(2): thr_up = t2_c;
      default:        thr_up = t3_c;
    endcase
    case (current_level)
      LEVEL_BITS'(2): thr_dn = t1_c;
      LEVEL_BITS'(3): thr_dn = t2_c;
      default:        thr_dn = t3_c;
    endcase

    current_level_next = current_level;
    if (s1.read_valid) begin
      if (!average_loaded) begin
        current_level_next = raw_level;
      end else if (raw_level > current_level && current_level <= LEVEL_BITS'(3) &&
                   avg_c > thr_up + hyst_c) begin
        current_level_next = raw_level;
      end else if (raw_level < current_level && current_level >= LEVEL_BITS'(2) &&
                   avg_c < thr_dn - hyst_c) begin
        current_level_next = raw_level;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Status classification, on the state after this read.
  // --------------------------------------------------------------------------
  always_comb begin
    if (s1.charge_active && !s1.power_good) begin
      status_next = ST_FAULT;
    end else if (!(average_loaded || s1.read_valid)) begin
      status_next = ST_UNAVAILABLE;
    end else if (!s1.read_valid) begin
      status_next = ST_FAULT;
    end else if (s1.power_good) begin
      status_next = s1.charge_active ? ST_CHARGING : ST_COMPLETE;
    end else if (current_level_next <= low_level_limit) begin
      status_next = ST_LOW;
    end else begin
      status_next = ST_ON_BATTERY;
    end
  end

  // --------------------------------------------------------------------------
  // State update and result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      running_average <= '0;
      average_loaded  <= 1'b0;
      current_level   <= '0;
      last_read_good  <= 1'b0;
      results.valid   <= 1'b0;
    end else if (advance) begin
      results.valid <= s1_valid;
      if (s1_valid) begin
        running_average <= running_average_next;
        average_loaded  <= average_loaded || s1.read_valid;
        current_level   <= current_level_next;
        last_read_good  <= s1.read_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      results.battery_level  <= current_level_next;
      results.battery_status <= status_next;
      results.filtered_value <= running_average_next;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `BLG_ASSERT_IMPL(a_level_range, average_loaded,
                   current_level >= LEVEL_BITS'(1) && current_level <= LEVEL_BITS'(4))
  `BLG_ASSERT_IMPL(a_empty_state, !average_loaded,
                   current_level == '0 && running_average == '0 && !last_read_good)
  `BLG_ASSERT_NEXT(a_stage_moves, s1_valid && advance, results.valid)
  `BLG_ASSERT_IMPL(a_unavail_level, results.valid && results.battery_status == ST_UNAVAILABLE,
                   results.battery_level == '0)

endmodule
